### hdl/wrq_pkg.sv
// Package for the worker ready queue with expiry.
// Holds sizes, payload structs, operation and status codes, FSM states and helpers.
// No dependencies.
package wrq_pkg;

    localparam int QUEUE_DEPTH = 16;
    localparam int ID_BITS     = 8;
    localparam int TIME_BITS   = 32;

    localparam int IDX_W  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);
    localparam int UNIT_W = (TIME_BITS > ID_BITS) ? TIME_BITS : ID_BITS;

    localparam int OPERATION_W = 3;
    localparam int WORKER_ID_W = 8;
    localparam int STATUS_W    = 3;
    localparam int ENTRY_CNT_W = 5;
    localparam int HEAD_ID_W   = 8;
    localparam int DROPPED_W   = 5;

    localparam int TTL_W      = 20;
    localparam int TTL_RESET  = 3;
    localparam int APB_DATA_W = 32;
    localparam int APB_ADDR_W = 3;
    localparam logic CFG_TTL_IDX = 1'b0;

    typedef struct packed {
        logic [OPERATION_W-1:0] operation;
        logic [WORKER_ID_W-1:0] worker_id;
    } t_in_item;

    typedef struct packed {
        logic [STATUS_W-1:0]    status;
        logic [ENTRY_CNT_W-1:0] entry_count;
        logic                   head_valid;
        logic [HEAD_ID_W-1:0]   head_id;
        logic [DROPPED_W-1:0]   dropped_count;
    } t_out_item;

    typedef enum logic [OPERATION_W-1:0] {
        OP_TICK    = 3'd0,
        OP_PUSH    = 3'd1,
        OP_REFRESH = 3'd2,
        OP_ERASE   = 3'd3,
        OP_POP     = 3'd4,
        OP_PURGE   = 3'd5
    } t_op;

    typedef enum logic [STATUS_W-1:0] {
        STAT_OK      = 3'd0,
        STAT_PRESENT = 3'd1,
        STAT_ABSENT  = 3'd2,
        STAT_FULL    = 3'd3,
        STAT_EMPTY   = 3'd4
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_FINISH,
        S_HEAD
    } t_state;

    typedef struct packed {
        logic equal;
        logic later;
    } t_cmp_res;

    function automatic logic [IDX_W-1:0] wrap_index(input logic [IDX_W:0] sum);
        logic [IDX_W:0] red;
        red = sum;
        if (sum >= (IDX_W+1)'(QUEUE_DEPTH)) begin
            red = sum - (IDX_W+1)'(QUEUE_DEPTH);
        end
        return red[IDX_W-1:0];
    endfunction

endpackage

### hdl/wrq_cmp_unit.sv
// Shared subtract-and-compare unit of the worker queue.
// Gives equality of identifiers and modular "later than" of time stamps.
// Depends on wrq_pkg.
module wrq_cmp_unit (
    input  logic [wrq_pkg::UNIT_W-1:0] i_a,
    input  logic [wrq_pkg::UNIT_W-1:0] i_b,
    output wrq_pkg::t_cmp_res          o_res
);

    logic [wrq_pkg::UNIT_W-1:0] diff;

    assign diff = i_a - i_b;

    always_comb begin
        o_res.equal = (diff == '0);
        o_res.later = (diff[wrq_pkg::TIME_BITS-1:0] != '0) && !diff[wrq_pkg::TIME_BITS-1];
    end

endmodule

### hdl/wrq_apb_regs.sv
// Configuration register block of the worker queue on an APB-style port.
// Holds the time-to-live register.
// Depends on wrq_pkg.
module wrq_apb_regs (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [wrq_pkg::APB_ADDR_W-1:0]   paddr,
    input  logic [wrq_pkg::APB_DATA_W-1:0]   pwdata,
    output logic [wrq_pkg::APB_DATA_W-1:0]   prdata,
    output logic                             pready,
    output logic [wrq_pkg::TTL_W-1:0]        o_ttl
);

    logic [wrq_pkg::TTL_W-1:0] r_ttl;
    logic                      sel_ttl;

    assign sel_ttl = (paddr[2] == wrq_pkg::CFG_TTL_IDX);
    assign pready  = 1'b1;
    assign o_ttl   = r_ttl;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ttl <= wrq_pkg::TTL_W'(wrq_pkg::TTL_RESET);
        end else if (psel && penable && pwrite && pready && sel_ttl) begin
            r_ttl <= pwdata[wrq_pkg::TTL_W-1:0];
        end
    end

    always_comb begin
        prdata = '0;
        if (sel_ttl) begin
            prdata = wrq_pkg::APB_DATA_W'(r_ttl);
        end
    end

endmodule

### hdl/worker_ready_queue_with_expiry.sv
// Worker ready queue with expiry: top level with the sequencer and entry store.
// Depends on wrq_pkg, wrq_cmp_unit and wrq_apb_regs.
// Push, refresh, erase and purge walk the queue one entry a cycle in the scan state,
// then pass S_FINISH and S_HEAD; tick, pop and unused codes skip the scan. The result
// is registered on leaving S_HEAD, and the next transaction is taken back in idle. A held
// output stalls S_HEAD. Synchronous reset clears count, head and time, ttl is 3.
module worker_ready_queue_with_expiry (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  wrq_pkg::t_in_item              i_in_data,
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output wrq_pkg::t_out_item             o_out_data,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [wrq_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [wrq_pkg::APB_DATA_W-1:0] pwdata,
    output logic [wrq_pkg::APB_DATA_W-1:0] prdata,
    output logic                           pready
);

    localparam int DEPTH = wrq_pkg::QUEUE_DEPTH;
    localparam int IW    = wrq_pkg::IDX_W;
    localparam int CW    = wrq_pkg::CNT_W;
    localparam int TW    = wrq_pkg::TIME_BITS;
    localparam int DW    = wrq_pkg::ID_BITS;

    logic [DW-1:0] r_mem_id  [DEPTH];
    logic [TW-1:0] r_mem_exp [DEPTH];

    wrq_pkg::t_state    r_state, n_state;
    wrq_pkg::t_op       r_op, n_op;
    wrq_pkg::t_status   r_status, n_status;
    logic [DW-1:0]      r_id, n_id;
    logic [CW-1:0]      r_k, n_k;
    logic [CW-1:0]      r_w, n_w;
    logic [CW-1:0]      r_occ, n_occ;
    logic [CW-1:0]      r_dropped, n_dropped;
    logic [IW-1:0]      r_head, n_head;
    logic [TW-1:0]      r_time, n_time;
    logic               r_found, n_found;
    logic               r_out_valid, n_out_valid;
    wrq_pkg::t_out_item r_out, n_out;
    logic [DW-1:0]      r_rd_id;
    logic [TW-1:0]      r_rd_exp;

    logic [wrq_pkg::TTL_W-1:0] ttl;
    logic [TW-1:0]             new_exp;
    logic [IW-1:0]             scan_slot, keep_slot, tail_slot, rd_addr;
    logic                      wr_en;
    logic [IW-1:0]             wr_addr;
    logic [DW-1:0]             wr_id;
    logic [TW-1:0]             wr_exp;
    logic [wrq_pkg::UNIT_W-1:0] cmp_a, cmp_b;
    wrq_pkg::t_cmp_res         cmp;
    logic                      in_fire;

    wrq_apb_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_ttl   (ttl)
    );

    wrq_cmp_unit u_cmp (
        .i_a   (cmp_a),
        .i_b   (cmp_b),
        .o_res (cmp)
    );

    assign o_in_ready  = (r_state == wrq_pkg::S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;
    assign in_fire     = i_in_valid && o_in_ready;

    assign new_exp   = r_time + TW'(ttl);
    assign scan_slot = wrq_pkg::wrap_index({1'b0, r_head} + {1'b0, r_k[IW-1:0]});
    assign keep_slot = wrq_pkg::wrap_index({1'b0, r_head} + {1'b0, r_w[IW-1:0]});
    assign tail_slot = wrq_pkg::wrap_index({1'b0, r_head} + {1'b0, r_occ[IW-1:0]});
    assign rd_addr   = (n_state == wrq_pkg::S_HEAD) ? n_head :
                       wrq_pkg::wrap_index({1'b0, n_head} + {1'b0, n_k[IW-1:0]});

    always_comb begin
        if (r_op == wrq_pkg::OP_PURGE) begin
            cmp_a = wrq_pkg::UNIT_W'(r_time);
            cmp_b = wrq_pkg::UNIT_W'(r_rd_exp);
        end else begin
            cmp_a = wrq_pkg::UNIT_W'(r_id);
            cmp_b = wrq_pkg::UNIT_W'(r_rd_id);
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem_id[wr_addr]  <= wr_id;
            r_mem_exp[wr_addr] <= wr_exp;
        end
        if (wr_en && (wr_addr == rd_addr)) begin
            r_rd_id  <= wr_id;
            r_rd_exp <= wr_exp;
        end else begin
            r_rd_id  <= r_mem_id[rd_addr];
            r_rd_exp <= r_mem_exp[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= wrq_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_occ       <= '0;
            r_head      <= '0;
            r_time      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_occ       <= n_occ;
            r_head      <= n_head;
            r_time      <= n_time;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op      <= n_op;
        r_status  <= n_status;
        r_id      <= n_id;
        r_k       <= n_k;
        r_w       <= n_w;
        r_dropped <= n_dropped;
        r_found   <= n_found;
        r_out     <= n_out;
    end

    always_comb begin
        n_state     = r_state;
        n_op        = r_op;
        n_status    = r_status;
        n_id        = r_id;
        n_k         = r_k;
        n_w         = r_w;
        n_occ       = r_occ;
        n_dropped   = r_dropped;
        n_head      = r_head;
        n_time      = r_time;
        n_found     = r_found;
        n_out       = r_out;
        n_out_valid = r_out_valid && !i_out_ready;
        wr_en       = 1'b0;
        wr_addr     = keep_slot;
        wr_id       = r_rd_id;
        wr_exp      = r_rd_exp;

        case (r_state)
            wrq_pkg::S_IDLE: begin
                if (in_fire) begin
                    n_op      = wrq_pkg::t_op'(i_in_data.operation);
                    n_id      = DW'(i_in_data.worker_id);
                    n_k       = '0;
                    n_w       = '0;
                    n_found   = 1'b0;
                    n_dropped = '0;
                    n_status  = wrq_pkg::STAT_OK;
                    if (i_in_data.operation inside {wrq_pkg::OP_PUSH, wrq_pkg::OP_REFRESH,
                                                    wrq_pkg::OP_ERASE, wrq_pkg::OP_PURGE}) begin
                        n_state = wrq_pkg::S_SCAN;
                    end else begin
                        n_state = wrq_pkg::S_FINISH;
                    end
                end
            end
            wrq_pkg::S_SCAN: begin
                if (r_k == r_occ) begin
                    n_state = wrq_pkg::S_FINISH;
                end else begin
                    n_k = r_k + CW'(1);
                    case (r_op)
                        wrq_pkg::OP_PUSH: begin
                            if (cmp.equal) begin
                                n_found = 1'b1;
                            end
                        end
                        wrq_pkg::OP_REFRESH: begin
                            if (cmp.equal) begin
                                n_found = 1'b1;
                                wr_en   = 1'b1;
                                wr_addr = scan_slot;
                                wr_exp  = new_exp;
                            end
                        end
                        wrq_pkg::OP_ERASE: begin
                            if (cmp.equal && !r_found) begin
                                n_found = 1'b1;
                            end else begin
                                wr_en = 1'b1;
                                n_w   = r_w + CW'(1);
                            end
                        end
                        wrq_pkg::OP_PURGE: begin
                            if (cmp.later) begin
                                n_dropped = r_dropped + CW'(1);
                            end else begin
                                wr_en = 1'b1;
                                n_w   = r_w + CW'(1);
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            wrq_pkg::S_FINISH: begin
                n_state = wrq_pkg::S_HEAD;
                case (r_op)
                    wrq_pkg::OP_TICK: begin
                        n_time = r_time + TW'(1);
                    end
                    wrq_pkg::OP_PUSH: begin
                        if (r_found) begin
                            n_status = wrq_pkg::STAT_PRESENT;
                        end else if (r_occ == CW'(DEPTH)) begin
                            n_status = wrq_pkg::STAT_FULL;
                        end else begin
                            wr_en   = 1'b1;
                            wr_addr = tail_slot;
                            wr_id   = r_id;
                            wr_exp  = new_exp;
                            n_occ   = r_occ + CW'(1);
                        end
                    end
                    wrq_pkg::OP_REFRESH: begin
                        if (!r_found) begin
                            n_status = wrq_pkg::STAT_ABSENT;
                        end
                    end
                    wrq_pkg::OP_ERASE: begin
                        if (!r_found) begin
                            n_status = wrq_pkg::STAT_ABSENT;
                        end
                        n_occ = r_w;
                    end
                    wrq_pkg::OP_POP: begin
                        if (r_occ == '0) begin
                            n_status = wrq_pkg::STAT_EMPTY;
                        end else begin
                            n_head = wrq_pkg::wrap_index({1'b0, r_head} + (IW+1)'(1));
                            n_occ  = r_occ - CW'(1);
                        end
                    end
                    wrq_pkg::OP_PURGE: begin
                        n_occ = r_w;
                    end
                    default: begin
                    end
                endcase
            end
            wrq_pkg::S_HEAD: begin
                if (!r_out_valid || i_out_ready) begin
                    n_out.status        = wrq_pkg::STATUS_W'(r_status);
                    n_out.entry_count   = wrq_pkg::ENTRY_CNT_W'(r_occ);
                    n_out.head_valid    = (r_occ != '0);
                    n_out.head_id       = (r_occ != '0) ? wrq_pkg::HEAD_ID_W'(r_rd_id) : '0;
                    n_out.dropped_count = (r_op == wrq_pkg::OP_PURGE) ?
                                          wrq_pkg::DROPPED_W'(r_dropped) : '0;
                    n_out_valid         = 1'b1;
                    n_state             = wrq_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = wrq_pkg::S_IDLE;
            end
        endcase
    end

    a_occ_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_occ <= CW'(DEPTH))
        else $error("occupancy exceeds queue depth");

    a_keep_behind_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == wrq_pkg::S_SCAN) |-> (r_w <= r_k && r_k <= r_occ))
        else $error("compaction write index passed the read index");

    a_accept_leaves_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_fire |=> (r_state != wrq_pkg::S_IDLE))
        else $error("accepted transaction did not start processing");

    a_tick_advances: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == wrq_pkg::S_FINISH && r_op == wrq_pkg::OP_TICK)
        |=> (r_time == $past(r_time) + TW'(1)))
        else $error("tick did not advance time");

    a_head_consistent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_data.head_valid == (o_out_data.entry_count != '0)))
        else $error("head valid disagrees with entry count");

endmodule
